@@ rtl/brs_pkg.sv @@
// Shared widths, defaults and register codes of the bilinear RGBA scaler.
package brs_pkg;

  // Field widths of the channels
  localparam int COORD_W    = 8;
  localparam int PIXEL_W    = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int SIZE_W     = 9;
  localparam int RATIO_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Default sizing of the frame store and the fixed-point format
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // Register reset values
  localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = SIZE_W'(256);
  localparam logic [RATIO_W-1:0] RST_H_RATIO    = RATIO_W'(65536);
  localparam logic [RATIO_W-1:0] RST_V_RATIO    = RATIO_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_H_RATIO    = 2'd2,
    CFG_V_RATIO    = 2'd3
  } cfg_reg_e;

endpackage

@@ rtl/brs_if.sv @@
// Valid/ready channel interfaces of the bilinear RGBA scaler.
interface brs_pix_in_if import brs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, kind, x_coord, y_coord, pixel_in, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, pixel_in, output ready);
endinterface

interface brs_pix_out_if import brs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface brs_cfg_if import brs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bilinear_rgba_scaler.sv @@
// Top level of the bilinear RGBA scaler: frame store and interpolation pipeline.
//   pix_in_i  - one item per handshake. kind 0 loads pixel_in into the frame
//               store at (x_coord, y_coord); kind 1 asks for output pixel
//               (col = x_coord, row = y_coord).
//   pix_out_o - one RGBA item for every compute item, in order. Loads give none.
//   cfg_i     - register writes (source width/height, horizontal/vertical
//               ratio), always ready; write only while the block is idle.
// Throughput: one item per cycle while pix_out_o is ready. The store is split
//   into four banks by column and row parity, so the whole 2x2 neighborhood
//   is read at once with a single read port per bank.
// Pipeline: five register stages (position multiply, neighbor clamp, bank
//   read plus weights, channel products, sum and truncate).
// Loads ride the first two stages and write the store as they leave stage 2,
//   the same step where computes read, so each compute sees exactly the
//   loads accepted before it.
// Stalls: every stage has its own valid bit and moves when the next one is
//   empty or moving, so bubbles close up; nothing is dropped or repeated.
// Reset clears the registers to their defaults and empties the pipeline;
//   the frame store is not cleared, read only what was loaded.
module bilinear_rgba_scaler import brs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  brs_cfg_if.sink       cfg_i,
  brs_pix_in_if.sink    pix_in_i,
  brs_pix_out_if.source pix_out_o
);

  localparam int XW   = $clog2(MAX_WIDTH);       // column index
  localparam int YW   = $clog2(MAX_HEIGHT);      // row index
  localparam int WW   = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int HW   = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int FW   = FRAC_BITS;
  localparam int PW   = COORD_W + RATIO_W;       // source position
  localparam int IPW  = PW - FW;                 // integer part
  localparam int NW   = FW + 1;                  // 1 - fraction
  localparam int WTW  = 2 * FW + 1;              // corner weight
  localparam int PRW  = WTW + CHAN_W;            // channel product
  localparam int ACW  = PRW + 2;                 // sum of four products
  localparam int NUM_BANKS  = 4;
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [NW-1:0] FRAC_ONE = {1'b1, {FW{1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]  src_width_q, src_height_q;
  logic [RATIO_W-1:0] h_ratio_q, v_ratio_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      h_ratio_q    <= RST_H_RATIO;
      v_ratio_q    <= RST_V_RATIO;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SRC_WIDTH:  src_width_q  <= cfg_i.data[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_i.data[SIZE_W-1:0];
        CFG_H_RATIO:    h_ratio_q    <= cfg_i.data[RATIO_W-1:0];
        CFG_V_RATIO:    v_ratio_q    <= cfg_i.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size: zero means one, above the store saturates.
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    if (src_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(src_width_q);
    end
    if (src_height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(src_height_q);
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage moves when it is empty or the next one moves.
  // Stages 1 and 2 hold either a compute (v*) or a load (lv*).
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic lv1_q, lv2_q;
  logic en1, en2, en3, en4, en5;
  logic in_acc;

  assign en5 = !v5_q || pix_out_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !(v2_q || lv2_q) || en3;
  assign en1 = !(v1_q || lv1_q) || en2;

  assign pix_in_i.ready = en1;
  assign in_acc         = pix_in_i.valid && en1;

  // ---------------------------------------------------------------------
  // Frame store write address: bank by parity, loads outside the store
  // dropped. The write itself happens when the load leaves stage 2.
  // ---------------------------------------------------------------------
  logic           ld_en;
  logic [1:0]     wr_bank;
  logic [BAW-1:0] wr_addr;

  assign ld_en   = in_acc && !pix_in_i.kind &&
                   (32'(pix_in_i.x_coord) < MAX_WIDTH) &&
                   (32'(pix_in_i.y_coord) < MAX_HEIGHT);
  assign wr_bank = {pix_in_i.y_coord[0], pix_in_i.x_coord[0]};
  assign wr_addr = BAW'(pix_in_i.y_coord >> 1) * BAW'(HALF_W) +
                   BAW'(pix_in_i.x_coord >> 1);

  // ---------------------------------------------------------------------
  // Stage 1: source position = coordinate * ratio
  // ---------------------------------------------------------------------
  logic               v1_d;
  logic [PW-1:0]      pos_x_d, pos_y_d, pos_x_q, pos_y_q;
  logic [1:0]         wr_bank1_q, wr_bank2_q;
  logic [BAW-1:0]     wr_addr1_q, wr_addr2_q;
  logic [PIXEL_W-1:0] wr_data1_q, wr_data2_q;

  assign v1_d    = in_acc && pix_in_i.kind;
  assign pos_x_d = PW'(pix_in_i.x_coord) * PW'(h_ratio_q);
  assign pos_y_d = PW'(pix_in_i.y_coord) * PW'(v_ratio_q);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      wr_bank1_q <= wr_bank;
      wr_addr1_q <= wr_addr;
      wr_data1_q <= pix_in_i.pixel_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: integer parts clamped, right/bottom neighbor, fractions
  // ---------------------------------------------------------------------
  logic [IPW-1:0] ip_x, ip_y;
  logic [XW-1:0]  j0_d, j1_d, j0_q, j1_q;
  logic [YW-1:0]  k0_d, k1_d, k0_q, k1_q;
  logic [FW-1:0]  t_d, u_d, t_q, u_q;

  assign ip_x = pos_x_q[PW-1:FW];
  assign ip_y = pos_y_q[PW-1:FW];
  assign t_d  = pos_x_q[FW-1:0];
  assign u_d  = pos_y_q[FW-1:0];

  always_comb begin
    if (32'(ip_x) >= 32'(eff_w)) begin
      j0_d = XW'(eff_w - WW'(1));
    end else begin
      j0_d = XW'(ip_x);
    end
    j1_d = (32'(j0_d) + 32'd1 < 32'(eff_w)) ? j0_d + XW'(1) : j0_d;
    if (32'(ip_y) >= 32'(eff_h)) begin
      k0_d = YW'(eff_h - HW'(1));
    end else begin
      k0_d = YW'(ip_y);
    end
    k1_d = (32'(k0_d) + 32'd1 < 32'(eff_h)) ? k0_d + YW'(1) : k0_d;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      j0_q       <= j0_d;
      j1_q       <= j1_d;
      k0_q       <= k0_d;
      k1_q       <= k1_d;
      t_q        <= t_d;
      u_q        <= u_d;
      wr_bank2_q <= wr_bank1_q;
      wr_addr2_q <= wr_addr1_q;
      wr_data2_q <= wr_data1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: bank reads and corner weights; a load leaving stage 2 writes
  // ---------------------------------------------------------------------
  logic [BAW-1:0]     rd_addr [NUM_BANKS];
  logic [PIXEL_W-1:0] bank_mem [NUM_BANKS][BANK_DEPTH];
  logic [PIXEL_W-1:0] rd_q [NUM_BANKS];
  logic [NW-1:0]      nt, nu;
  logic [WTW-1:0]     wa_d, wb_d, wc_d, wd_d, wa_q, wb_q, wc_q, wd_q;
  logic [1:0]         sel_a_q, sel_b_q, sel_c_q, sel_d_q;

  // Each bank takes whichever neighbor column and row has its parity.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      logic [1:0]    id;
      logic [XW-1:0] col;
      logic [YW-1:0] row;
      id         = 2'(b);
      col        = (j0_q[0] == id[0]) ? j0_q : j1_q;
      row        = (k0_q[0] == id[1]) ? k0_q : k1_q;
      rd_addr[b] = BAW'(row >> 1) * BAW'(HALF_W) + BAW'(col >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (lv2_q && en3 && wr_bank2_q == 2'(b)) begin
        bank_mem[b][wr_addr2_q] <= wr_data2_q;
      end
      if (en3) begin
        rd_q[b] <= bank_mem[b][rd_addr[b]];
      end
    end
  end

  assign nt   = FRAC_ONE - NW'(t_q);
  assign nu   = FRAC_ONE - NW'(u_q);
  assign wa_d = WTW'(nt) * WTW'(nu);
  assign wb_d = WTW'(t_q) * WTW'(nu);
  assign wc_d = WTW'(nt) * WTW'(u_q);
  assign wd_d = WTW'(t_q) * WTW'(u_q);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      wa_q    <= wa_d;
      wb_q    <= wb_d;
      wc_q    <= wc_d;
      wd_q    <= wd_d;
      sel_a_q <= {k0_q[0], j0_q[0]};
      sel_b_q <= {k0_q[0], j1_q[0]};
      sel_c_q <= {k1_q[0], j0_q[0]};
      sel_d_q <= {k1_q[0], j1_q[0]};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: route banks to corners, weight every channel
  // ---------------------------------------------------------------------
  logic [PIXEL_W-1:0] px_a, px_b, px_c, px_d;
  logic [PRW-1:0]     pa_d [NUM_CHAN];
  logic [PRW-1:0]     pb_d [NUM_CHAN];
  logic [PRW-1:0]     pc_d [NUM_CHAN];
  logic [PRW-1:0]     pd_d [NUM_CHAN];
  logic [PRW-1:0]     pa_q [NUM_CHAN];
  logic [PRW-1:0]     pb_q [NUM_CHAN];
  logic [PRW-1:0]     pc_q [NUM_CHAN];
  logic [PRW-1:0]     pd_q [NUM_CHAN];

  assign px_a = rd_q[sel_a_q];
  assign px_b = rd_q[sel_b_q];
  assign px_c = rd_q[sel_c_q];
  assign px_d = rd_q[sel_d_q];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      pa_d[c] = PRW'(px_a[c*CHAN_W +: CHAN_W]) * PRW'(wa_q);
      pb_d[c] = PRW'(px_b[c*CHAN_W +: CHAN_W]) * PRW'(wb_q);
      pc_d[c] = PRW'(px_c[c*CHAN_W +: CHAN_W]) * PRW'(wc_q);
      pd_d[c] = PRW'(px_d[c*CHAN_W +: CHAN_W]) * PRW'(wd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
      pd_q <= pd_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum and drop the 2*FRAC_BITS fraction bits (output register)
  // ---------------------------------------------------------------------
  logic [ACW-1:0]    acc [NUM_CHAN];
  logic [CHAN_W-1:0] chan_d [NUM_CHAN];
  logic [CHAN_W-1:0] chan_q [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc[c]    = ACW'(pa_q[c]) + ACW'(pb_q[c]) + ACW'(pc_q[c]) + ACW'(pd_q[c]);
      chan_d[c] = acc[c][2*FW +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      chan_q <= chan_d;
    end
  end

  assign pix_out_o.valid = v5_q;
  assign pix_out_o.red   = chan_q[0];
  assign pix_out_o.green = chan_q[1];
  assign pix_out_o.blue  = chan_q[2];
  assign pix_out_o.alpha = chan_q[3];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      lv1_q <= 1'b0;
      lv2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q  <= v1_d;
        lv1_q <= ld_en;
      end
      if (en2) begin
        v2_q  <= v1_q;
        lv2_q <= lv1_q;
      end
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_compute_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pix_in_i.kind |=> v1_q)
    else $error("compute item did not enter the pipeline");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !pix_in_i.kind |=> !v1_q)
    else $error("load item entered the result pipeline");

  a_col_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((j1_q == j0_q) || (j1_q == j0_q + XW'(1))) &&
             (32'(j1_q) < 32'(eff_w)))
    else $error("column neighbor out of range");

  a_row_neighbor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ((k1_q == k0_q) || (k1_q == k0_q + YW'(1))) &&
             (32'(k1_q) < 32'(eff_h)))
    else $error("row neighbor out of range");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (ACW'(wa_q) + ACW'(wb_q) + ACW'(wc_q) + ACW'(wd_q)) ==
             (ACW'(1) << (2 * FW)))
    else $error("corner weights do not sum to one");

endmodule

@@ verif/tb_bilinear_rgba_scaler.sv @@
// Self-checking testbench of the bilinear RGBA scaler: random stalls, predictor and scoreboard.
`timescale 1ns / 100ps

module tb_bilinear_rgba_scaler;
  import brs_pkg::*;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  localparam int FRAC_BITS      = DEF_FRAC_BITS;
  localparam int STORE_DEPTH    = MAX_W * MAX_H;
  localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;

  localparam int RESET_CYCLES   = 12;
  localparam int PIPE_SETTLE    = 8;     // lets the last results and trailing loads clear the pipeline
  localparam int HOLD_AFTER     = 30;    // results seen before the long output stall
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_COMPUTE = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e         kind;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [PIXEL_W-1:0] pixel;
  } pix_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  logic clk_i;
  logic rst_ni;

  brs_cfg_if     cfg_bus ();
  brs_pix_in_if  pix_in_bus ();
  brs_pix_out_if pix_out_bus ();

  bilinear_rgba_scaler i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_bus),
    .pix_in_i  (pix_in_bus),
    .pix_out_o (pix_out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: copy of the registers and of the frame store, updated at
  // the handshakes. loaded_map is the generator's view of which store entries
  // are already queued for loading; computes never touch anything else.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  src_width_model;
  logic [SIZE_W-1:0]  src_height_model;
  logic [RATIO_W-1:0] h_ratio_model;
  logic [RATIO_W-1:0] v_ratio_model;
  logic [PIXEL_W-1:0] frame_model [STORE_DEPTH];
  bit                 loaded_map  [STORE_DEPTH];

  pix_item_t pix_queue[$];        // items waiting for the driver
  rgba_t     expected_pixels[$];  // predicted output pixels, oldest first

  int unsigned items_queued;
  int unsigned results_checked;
  int unsigned error_count;
  bit          no_gaps;           // phase with back-to-back traffic on both sides

  function automatic int unsigned store_index(input int unsigned col, input int unsigned row);
    return row * MAX_W + col;
  endfunction

  // Zero reads as one pixel, oversize saturates to the store.
  function automatic int unsigned effective_size(input logic [SIZE_W-1:0] value,
                                                 input int unsigned limit);
    if (value == '0) return 1;
    return (value > limit) ? limit : value;
  endfunction

  // Integer part picks the base, clamped to the last column/row; the next
  // neighbor folds back onto the base at the right or bottom edge.
  function automatic void locate_axis(input longint unsigned pos, input int unsigned size,
                                      output int unsigned lo, output int unsigned hi,
                                      output longint unsigned frac);
    longint unsigned ip;
    ip   = pos >> FRAC_BITS;
    frac = pos & (FRAC_ONE - 1);
    if (ip >= size) ip = size - 1;
    lo = 32'(ip);
    hi = (ip + 1 < size) ? lo + 1 : lo;
  endfunction

  function automatic void neighborhood(input logic [COORD_W-1:0] col, row,
                                       output int unsigned j0, j1, k0, k1,
                                       output longint unsigned t, u);
    locate_axis(64'(col) * 64'(h_ratio_model), effective_size(src_width_model, MAX_W),
                j0, j1, t);
    locate_axis(64'(row) * 64'(v_ratio_model), effective_size(src_height_model, MAX_H),
                k0, k1, u);
  endfunction

  function automatic rgba_t interpolate_pixel(input logic [COORD_W-1:0] col, row);
    int unsigned                     j0, j1, k0, k1;
    longint unsigned                 t, u, wa, wb, wc, wd, acc;
    logic [PIXEL_W-1:0]              sa, sb, sc, sd;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
    neighborhood(col, row, j0, j1, k0, k1, t, u);
    wa = (FRAC_ONE - t) * (FRAC_ONE - u);
    wb = t * (FRAC_ONE - u);
    wc = (FRAC_ONE - t) * u;
    wd = t * u;
    sa = frame_model[store_index(j0, k0)];
    sb = frame_model[store_index(j1, k0)];
    sc = frame_model[store_index(j0, k1)];
    sd = frame_model[store_index(j1, k1)];
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc = sa[ch*CHAN_W +: CHAN_W] * wa + sb[ch*CHAN_W +: CHAN_W] * wb
          + sc[ch*CHAN_W +: CHAN_W] * wc + sd[ch*CHAN_W +: CHAN_W] * wd;
      chan[ch] = acc[2*FRAC_BITS +: CHAN_W];
    end
    return '{red: chan[0], green: chan[1], blue: chan[2], alpha: chan[3]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_channel(input string name, input logic [CHAN_W-1:0] got,
                               input logic [CHAN_W-1:0] wanted);
    if (got !== wanted)
      report_mismatch($sformatf("pixel %0d %s got %h, want %h",
                                results_checked, name, got, wanted));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_item(input item_kind_e kind, input logic [COORD_W-1:0] x, y,
                            input logic [PIXEL_W-1:0] pixel);
    pix_queue.push_back('{kind: kind, x_coord: x, y_coord: y, pixel: pixel});
    if (kind == KIND_LOAD) loaded_map[store_index(x, y)] = 1'b1;
    items_queued++;
  endtask

  // A compute preceded by loads of whatever part of its 2x2 neighborhood is
  // still empty, so the block never uses an unwritten entry.
  task automatic queue_output_pixel(input logic [COORD_W-1:0] col, row);
    int unsigned     j0, j1, k0, k1;
    longint unsigned t, u;
    neighborhood(col, row, j0, j1, k0, k1, t, u);
    if (!loaded_map[store_index(j0, k0)])
      queue_item(KIND_LOAD, COORD_W'(j0), COORD_W'(k0), random_pixel());
    if (!loaded_map[store_index(j1, k0)])
      queue_item(KIND_LOAD, COORD_W'(j1), COORD_W'(k0), random_pixel());
    if (!loaded_map[store_index(j0, k1)])
      queue_item(KIND_LOAD, COORD_W'(j0), COORD_W'(k1), random_pixel());
    if (!loaded_map[store_index(j1, k1)])
      queue_item(KIND_LOAD, COORD_W'(j1), COORD_W'(k1), random_pixel());
    queue_item(KIND_COMPUTE, col, row, $urandom());
  endtask

  // Mostly well-formed load/compute runs, about a fifth stray loads anywhere.
  task automatic run_random_phase(input int unsigned item_goal, input int unsigned coord_max);
    int unsigned goal;
    goal = items_queued + item_goal;
    while (items_queued < goal) begin
      if ($urandom_range(0, 9) < 2)
        queue_item(KIND_LOAD, COORD_W'($urandom_range(0, 255)),
                   COORD_W'($urandom_range(0, 255)), random_pixel());
      else
        queue_output_pixel(COORD_W'($urandom_range(0, coord_max)),
                           COORD_W'($urandom_range(0, coord_max)));
    end
  endtask

  // Everything sent, every pixel back, pipeline flushed of trailing loads.
  task automatic wait_for_drain();
    while (pix_queue.size() != 0 || pix_in_bus.valid || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic program_setting(input logic [SIZE_W-1:0] width, height,
                                 input logic [RATIO_W-1:0] h_ratio, v_ratio);
    wait_for_drain();
    write_register(CFG_SRC_WIDTH, CFG_DATA_W'(width));
    write_register(CFG_SRC_HEIGHT, CFG_DATA_W'(height));
    write_register(CFG_H_RATIO, h_ratio);
    write_register(CFG_V_RATIO, v_ratio);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item from the queue at a time, random gap after each item unless no_gaps is set.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin : pix_driver
    pix_item_t item;
    if (!rst_ni) begin
      pix_in_bus.valid    <= 1'b0;
      pix_in_bus.kind     <= KIND_LOAD;
      pix_in_bus.x_coord  <= '0;
      pix_in_bus.y_coord  <= '0;
      pix_in_bus.pixel_in <= '0;
      send_gap            <= 0;
    end else if (pix_in_bus.valid && !pix_in_bus.ready) begin
      // item still on offer
    end else if (send_gap != 0) begin
      pix_in_bus.valid <= 1'b0;
      send_gap         <= send_gap - 1;
    end else if (pix_queue.size() != 0) begin
      item = pix_queue.pop_front();
      pix_in_bus.valid    <= 1'b1;
      pix_in_bus.kind     <= item.kind;
      pix_in_bus.x_coord  <= item.x_coord;
      pix_in_bus.y_coord  <= item.y_coord;
      pix_in_bus.pixel_in <= item.pixel;
      send_gap            <= no_gaps ? 0 : $urandom_range(0, 9);
    end else begin
      pix_in_bus.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks results against the oldest prediction, feeds the
  // predictor from accepted items and register writes, and throttles the
  // output ready. Once, after HOLD_AFTER results, ready stays low for a long
  // stretch so the pipeline backs up into the input.
  // ---------------------------------------------------------------------------
  int unsigned recv_stall;
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin : pix_monitor
    rgba_t       wanted;
    int unsigned draw;
    if (!rst_ni) begin
      pix_out_bus.ready <= 1'b0;
      recv_stall        <= 0;
      hold_left         <= 0;
      hold_done         <= 1'b0;
      src_width_model   = RST_SRC_WIDTH;
      src_height_model  = RST_SRC_HEIGHT;
      h_ratio_model     = RST_H_RATIO;
      v_ratio_model     = RST_V_RATIO;
    end else begin
      if (pix_out_bus.valid && pix_out_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d with no request pending: %h %h %h %h",
                                    results_checked, pix_out_bus.red, pix_out_bus.green,
                                    pix_out_bus.blue, pix_out_bus.alpha));
        end else begin
          wanted = expected_pixels.pop_front();
          check_channel("red", pix_out_bus.red, wanted.red);
          check_channel("green", pix_out_bus.green, wanted.green);
          check_channel("blue", pix_out_bus.blue, wanted.blue);
          check_channel("alpha", pix_out_bus.alpha, wanted.alpha);
        end
        results_checked++;
      end

      if (pix_in_bus.valid && pix_in_bus.ready) begin
        if (pix_in_bus.kind == KIND_LOAD)
          frame_model[store_index(pix_in_bus.x_coord, pix_in_bus.y_coord)] =
            pix_in_bus.pixel_in;
        else
          expected_pixels.push_back(interpolate_pixel(pix_in_bus.x_coord,
                                                      pix_in_bus.y_coord));
      end

      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_SRC_WIDTH:  src_width_model  = cfg_bus.data[SIZE_W-1:0];
          CFG_SRC_HEIGHT: src_height_model = cfg_bus.data[SIZE_W-1:0];
          CFG_H_RATIO:    h_ratio_model    = cfg_bus.data[RATIO_W-1:0];
          CFG_V_RATIO:    v_ratio_model    = cfg_bus.data[RATIO_W-1:0];
          default: ;
        endcase
      end

      if (hold_left != 0) begin
        pix_out_bus.ready <= 1'b0;
        hold_left         <= hold_left - 1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
        pix_out_bus.ready <= 1'b0;
        hold_left         <= HOLD_CYCLES;
        hold_done         <= 1'b1;
      end else if (pix_out_bus.valid && pix_out_bus.ready) begin
        draw              = no_gaps ? 0 : $urandom_range(0, 9);
        recv_stall        <= draw;
        pix_out_bus.ready <= (draw == 0);
      end else if (recv_stall != 0) begin
        recv_stall        <= recv_stall - 1;
        pix_out_bus.ready <= (recv_stall == 1);
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  wire any_handshake = (pix_in_bus.valid && pix_in_bus.ready)
                    || (pix_out_bus.valid && pix_out_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready);
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || any_handshake) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_SRC_WIDTH;
    cfg_bus.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset sizes, unit ratios: plain copies, corners of the store.
    queue_item(KIND_LOAD, 0, 0, '1);
    queue_output_pixel(0, 0);
    queue_output_pixel(255, 255);
    queue_output_pixel(255, 0);
    queue_output_pixel(0, 255);

    // 3x2 image at half steps: interior blend, exact hits, right and
    // bottom edges folding onto the last column and row.
    program_setting(3, 2, 24'h008000, 24'h008000);
    queue_item(KIND_LOAD, 0, 0, 32'hFFFF_FFFF);
    queue_item(KIND_LOAD, 1, 0, 32'h0000_0000);
    queue_item(KIND_LOAD, 2, 0, 32'h1234_5678);
    queue_item(KIND_LOAD, 0, 1, 32'h8080_8080);
    queue_item(KIND_LOAD, 1, 1, 32'hFF00_FF00);
    queue_item(KIND_LOAD, 2, 1, 32'h0000_FFFF);
    queue_output_pixel(1, 1);
    queue_output_pixel(5, 3);
    queue_output_pixel(3, 0);
    queue_output_pixel(4, 2);

    // Zero width, oversize height, largest and zero ratio: positions far
    // past the image saturate, vertical position pinned at row zero.
    program_setting(0, 511, 24'hFF_FFFF, 24'h00_0000);
    queue_output_pixel(255, 0);
    queue_output_pixel(1, 200);
    queue_output_pixel(0, 0);

    // Small image, random ratios, random stalls; the long output hold lands here.
    program_setting(8, 6, RATIO_W'($urandom_range(0, 24'h02_0000)),
                    RATIO_W'($urandom_range(0, 24'h02_0000)));
    run_random_phase(150, 31);

    // Saturating width, full-range horizontal ratio, no idle cycles at all.
    program_setting(300, 256, RATIO_W'($urandom()),
                    RATIO_W'($urandom_range(0, 24'h02_0000)));
    no_gaps = 1'b1;
    run_random_phase(80, 255);

    // Single-pixel image.
    program_setting(1, 0, 24'h00_0000, 24'hFF_FFFF);
    no_gaps = 1'b0;
    run_random_phase(40, 255);

    program_setting(SIZE_W'($urandom_range(1, 256)), SIZE_W'($urandom_range(1, 256)),
                    RATIO_W'($urandom_range(0, 24'h04_0000)),
                    RATIO_W'($urandom_range(0, 24'h04_0000)));
    run_random_phase(100, 255);

    wait_for_drain();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/brs_pkg.sv
rtl/brs_if.sv
rtl/bilinear_rgba_scaler.sv
verif/tb_bilinear_rgba_scaler.sv
